// File: rtl/i2ctrf_pkg.sv
// Shared types and constants for the I2C target register file.
package i2ctrf_pkg;

    typedef enum logic [2:0] {
        KIND_ADDR    = 3'd0,
        KIND_READ    = 3'd1,
        KIND_WRITE   = 3'd2,
        KIND_STOP    = 3'd3,
        KIND_COLL    = 3'd4,
        KIND_BUS_ERR = 3'd5,
        KIND_LOCAL   = 3'd6
    } t_kind;

    localparam logic [1:0] RESP_NONE = 2'd0;
    localparam logic [1:0] RESP_ACK  = 2'd1;
    localparam logic [1:0] RESP_NACK = 2'd2;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_COLL = 2'd1;
    localparam logic [1:0] ERR_BUS  = 2'd2;

    localparam logic [1:0] CFG_OWN_ADDR    = 2'd0;
    localparam logic [1:0] CFG_VERSION     = 2'd1;
    localparam logic [1:0] CFG_NOTIFY_MASK = 2'd2;
    localparam logic [1:0] CFG_ERR_ENABLE  = 2'd3;

    localparam logic [7:0] SLOT_VERSION = 8'd0;
    localparam logic [7:0] SLOT_SWITCH  = 8'd1;
    localparam logic [7:0] SLOT_LED1    = 8'd2;
    localparam logic [7:0] SLOT_LED2    = 8'd3;
    localparam logic [7:0] SLOT_FAULT   = 8'd4;
    localparam logic [7:0] SLOT_CURRENT = 8'd5;
    localparam logic [7:0] SLOT_VOLTAGE = 8'd6;
    localparam logic [7:0] SLOT_POWER   = 8'd7;

    localparam int DIV_CURRENT = 5;
    localparam int DIV_VOLTAGE = 25;
    localparam int DIV_POWER   = 125;

    // reciprocal multiply, exact for dividends below 2**15
    localparam int RECIP_SHIFT = 22;
    localparam logic [19:0] RECIP_CURRENT =
        20'((2 ** RECIP_SHIFT + DIV_CURRENT - 1) / DIV_CURRENT);
    localparam logic [19:0] RECIP_VOLTAGE =
        20'((2 ** RECIP_SHIFT + DIV_VOLTAGE - 1) / DIV_VOLTAGE);
    localparam logic [19:0] RECIP_POWER =
        20'((2 ** RECIP_SHIFT + DIV_POWER - 1) / DIV_POWER);

    localparam logic signed [31:0] LIM_CURRENT = 32'(256 * DIV_CURRENT);
    localparam logic signed [31:0] LIM_VOLTAGE = 32'(256 * DIV_VOLTAGE);
    localparam logic signed [31:0] LIM_POWER   = 32'(256 * DIV_POWER);

endpackage

// File: rtl/i2ctrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module i2ctrf_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/i2ctrf_scale.sv
// Register update rules: boolean store and scaled, clamped measurements.
module i2ctrf_scale (
    input  logic [7:0]         i_idx,
    input  logic signed [31:0] i_value,
    output logic               o_we,
    output logic [7:0]         o_wdata
);
    import i2ctrf_pkg::*;

    logic [19:0]        recip;
    logic signed [31:0] lim;
    logic               scaled;
    logic [34:0]        prod;
    logic [7:0]         quot;

    always_comb begin
        recip  = RECIP_CURRENT;
        lim    = LIM_CURRENT;
        scaled = 1'b0;
        o_we   = 1'b0;
        case (i_idx)
            SLOT_SWITCH, SLOT_LED1, SLOT_LED2, SLOT_FAULT: begin
                o_we = 1'b1;
            end
            SLOT_CURRENT: begin
                o_we   = 1'b1;
                scaled = 1'b1;
            end
            SLOT_VOLTAGE: begin
                o_we   = 1'b1;
                scaled = 1'b1;
                recip  = RECIP_VOLTAGE;
                lim    = LIM_VOLTAGE;
            end
            SLOT_POWER: begin
                o_we   = 1'b1;
                scaled = 1'b1;
                recip  = RECIP_POWER;
                lim    = LIM_POWER;
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    assign prod = 35'(i_value[14:0]) * 35'(recip);
    assign quot = prod[RECIP_SHIFT +: 8];

    always_comb begin
        if (!scaled) begin
            o_wdata = {7'd0, (i_value != 32'sd0)};
        end else if (i_value[31]) begin
            o_wdata = 8'd0;
        end else if (i_value >= lim) begin
            o_wdata = 8'hFF;
        end else begin
            o_wdata = quot;
        end
    end

endmodule

// File: rtl/i2c_target_register_file_top.sv
// I2C target register file: bus event decode, pointer control and register RAM.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one bus event or local
//   firmware update per transaction: i_kind, i_bus_byte, i_local_reg,
//   i_local_value. Every event yields exactly one result transaction on the
//   output channel (o_out_valid / i_out_ready): response, read data, notify
//   and error fields.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes own address,
//   version value, notify mask and error enable; it is always ready. It must be
//   written only while no event is in flight; the block does not enforce this.
//   Pipeline: an accepted event passes the RAM stage (register RAM read and
//   write) and then the output register before its result appears.
//   Throughput: one event per cycle unless stalled; the register RAM takes one
//   read and one write each cycle, forwarding when a read hits the entry being written.
//   Reset clears the pointer, bus phase, config and all register entries
//   (entry valid bits); no clearing pass is needed.
//   When the receiver stalls, the pipeline holds and o_in_ready drops.
module i2c_target_register_file_top #(
    parameter int NUM_REGS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic [7:0]         i_bus_byte,
    input  logic [2:0]         i_local_reg,
    input  logic signed [31:0] i_local_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_response,
    output logic               o_read_valid,
    output logic [7:0]         o_read_data,
    output logic               o_notify_valid,
    output logic [2:0]         o_notify_reg,
    output logic               o_notify_value,
    output logic [1:0]         o_error_code,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import i2ctrf_pkg::*;

    localparam int AW = $clog2(NUM_REGS);
    localparam logic [7:0] NumRegs8 = 8'(NUM_REGS);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ADDR = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    // config
    logic [6:0] r_own;
    logic [7:0] r_version;
    logic [2:0] r_mask;
    logic       r_err_en;

    // state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_ptr, n_ptr;
    logic [NUM_REGS-1:0] r_vld;

    // RAM stage
    logic          r_b_valid;
    logic [1:0]    r_b_resp;
    logic          r_b_rv;
    logic          r_b_ver;
    logic          r_b_fwd;
    logic [7:0]    r_b_fwd_data;
    logic          r_b_ent_vld;
    logic          r_b_nv;
    logic [2:0]    r_b_nr;
    logic          r_b_nval;
    logic [1:0]    r_b_err;
    logic          r_b_we;
    logic [AW-1:0] r_b_waddr;
    logic [7:0]    r_b_wdata;

    // output register
    logic       r_out_valid;
    logic [1:0] r_out_resp;
    logic       r_out_rv;
    logic [7:0] r_out_rd;
    logic       r_out_nv;
    logic [2:0] r_out_nr;
    logic       r_out_nval;
    logic [1:0] r_out_err;

    logic        advance, accept;
    t_kind       kind;
    logic        ptr_in;
    logic [7:0]  ptr_inc;
    logic        ptr_wrap;
    logic [AW-1:0] ptr_addr;
    logic [1:0]  resp;
    logic        rd_en;
    logic        nv;
    logic [2:0]  nr;
    logic        nval;
    logic [1:0]  err;
    logic        upd_go;
    logic [7:0]  upd_idx;
    logic signed [31:0] upd_val;
    logic        sc_we;
    logic [7:0]  sc_wdata;
    logic        ram_we;
    logic [7:0]  ram_q;
    logic        fwd;
    logic [7:0]  b_rd;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = advance;
    assign accept     = i_in_valid && advance;
    assign o_cfg_ready = 1'b1;

    assign kind     = t_kind'(i_kind);
    assign ptr_in   = r_ptr < NumRegs8;
    assign ptr_inc  = r_ptr + 8'd1;
    assign ptr_wrap = ptr_inc >= NumRegs8;
    assign ptr_addr = r_ptr[AW-1:0];

    always_comb begin
        n_phase = r_phase;
        n_ptr   = r_ptr;
        resp    = RESP_NONE;
        rd_en   = 1'b0;
        nv      = 1'b0;
        nr      = 3'd0;
        nval    = 1'b0;
        err     = ERR_NONE;
        upd_go  = 1'b0;
        upd_idx = r_ptr;
        upd_val = $signed({24'd0, i_bus_byte});
        case (kind)
            KIND_ADDR: begin
                if ({1'b0, r_own} == i_bus_byte) begin
                    n_phase = PH_ADDR;
                    resp    = RESP_ACK;
                end
            end
            KIND_READ: begin
                if (ptr_in) begin
                    rd_en = 1'b1;
                    n_ptr = ptr_wrap ? 8'd0 : ptr_inc;
                end
            end
            KIND_WRITE: begin
                if (r_phase == PH_ADDR) begin
                    n_ptr   = i_bus_byte;
                    resp    = RESP_ACK;
                    n_phase = PH_DATA;
                end else if (r_phase == PH_DATA && ptr_in) begin
                    upd_go = 1'b1;
                    n_ptr  = ptr_wrap ? 8'd0 : ptr_inc;
                    resp   = ptr_wrap ? RESP_NACK : RESP_ACK;
                    case (r_ptr)
                        SLOT_SWITCH: nv = r_mask[0];
                        SLOT_LED1:   nv = r_mask[1];
                        SLOT_LED2:   nv = r_mask[2];
                        default:     nv = 1'b0;
                    endcase
                    if (nv) begin
                        nr   = r_ptr[2:0];
                        nval = (i_bus_byte != 8'd0);
                    end
                end
            end
            KIND_STOP: begin
                n_phase = PH_IDLE;
            end
            KIND_COLL: begin
                err     = r_err_en ? ERR_COLL : ERR_NONE;
                n_phase = PH_IDLE;
            end
            KIND_BUS_ERR: begin
                err     = r_err_en ? ERR_BUS : ERR_NONE;
                n_phase = PH_IDLE;
            end
            KIND_LOCAL: begin
                upd_idx = {5'd0, i_local_reg};
                upd_val = i_local_value;
                upd_go  = upd_idx < NumRegs8;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    i2ctrf_scale u_scale (
        .i_idx   (upd_idx),
        .i_value (upd_val),
        .o_we    (sc_we),
        .o_wdata (sc_wdata)
    );

    assign ram_we = advance && r_b_valid && r_b_we;
    assign fwd    = r_b_valid && r_b_we && (r_b_waddr == ptr_addr);

    i2ctrf_ram #(
        .DEPTH (NUM_REGS),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_b_waddr),
        .i_wdata (r_b_wdata),
        .i_re    (accept && rd_en),
        .i_raddr (ptr_addr),
        .o_rdata (ram_q)
    );

    always_comb begin
        b_rd = 8'd0;
        if (r_b_rv) begin
            if (r_b_ver) begin
                b_rd = r_version;
            end else if (r_b_fwd) begin
                b_rd = r_b_fwd_data;
            end else if (r_b_ent_vld) begin
                b_rd = ram_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_resp     <= resp;
            r_b_rv       <= rd_en;
            r_b_ver      <= (r_ptr == SLOT_VERSION);
            r_b_fwd      <= fwd;
            r_b_fwd_data <= r_b_wdata;
            r_b_ent_vld  <= r_vld[ptr_addr];
            r_b_nv       <= nv;
            r_b_nr       <= nr;
            r_b_nval     <= nval;
            r_b_err      <= err;
            r_b_waddr    <= upd_idx[AW-1:0];
            r_b_wdata    <= sc_wdata;
        end
        if (advance) begin
            r_out_resp <= r_b_resp;
            r_out_rv   <= r_b_rv;
            r_out_rd   <= b_rd;
            r_out_nv   <= r_b_nv;
            r_out_nr   <= r_b_nr;
            r_out_nval <= r_b_nval;
            r_out_err  <= r_b_err;
        end
        if (!i_rst_n) begin
            r_own       <= 7'd0;
            r_version   <= 8'd0;
            r_mask      <= 3'd0;
            r_err_en    <= 1'b0;
            r_phase     <= PH_IDLE;
            r_ptr       <= 8'd0;
            r_vld       <= '0;
            r_b_valid   <= 1'b0;
            r_b_we      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_OWN_ADDR:    r_own     <= i_cfg_data[6:0];
                    CFG_VERSION:     r_version <= i_cfg_data;
                    CFG_NOTIFY_MASK: r_mask    <= i_cfg_data[2:0];
                    CFG_ERR_ENABLE:  r_err_en  <= i_cfg_data[0];
                    default:         r_own     <= r_own;
                endcase
            end
            if (ram_we) begin
                r_vld[r_b_waddr] <= 1'b1;
            end
            if (accept) begin
                r_phase <= n_phase;
                r_ptr   <= n_ptr;
            end
            if (advance) begin
                r_b_valid   <= accept;
                r_b_we      <= accept && upd_go && sc_we;
                r_out_valid <= r_b_valid;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_response     = r_out_resp;
    assign o_read_valid   = r_out_rv;
    assign o_read_data    = r_out_rd;
    assign o_notify_valid = r_out_nv;
    assign o_notify_reg   = r_out_nr;
    assign o_notify_value = r_out_nval;
    assign o_error_code   = r_out_err;

    a_read_no_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rv) |-> (r_out_resp == RESP_NONE))
        else $error("read result carries a bus response");

    a_notify_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_nv) |-> (r_out_resp != RESP_NONE))
        else $error("notify without write acknowledge");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && kind == KIND_READ && ptr_in) |=> (r_ptr < NumRegs8))
        else $error("pointer left range after read");

    a_no_version_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_b_waddr != SLOT_VERSION[AW-1:0]))
        else $error("RAM write to version slot");

    a_err_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err != ERR_NONE) |-> r_err_en)
        else $error("error reported while disabled");

endmodule

// File: dv/i2c_target_register_file_top_tb.sv
// Testbench for the I2C target register file: bus/local event stimulus, scoreboard, checks.
`timescale 1ns / 1ps

module i2c_target_register_file_top_tb;
    import i2ctrf_pkg::*;

    localparam int REG_COUNT = 8;
    localparam int BLOCK_EVENTS = 280;
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    typedef enum logic [1:0] {
        PHASE_IDLE,
        PHASE_ADDRESSED,
        PHASE_DATA
    } t_bus_phase;

    typedef struct packed {
        logic [1:0] response;
        logic       read_valid;
        logic [7:0] read_data;
        logic       notify_valid;
        logic [2:0] notify_reg;
        logic       notify_value;
        logic [1:0] error_code;
    } t_bus_result;

    class reg_file_scoreboard;
        logic [6:0]  own_addr;
        logic [7:0]  version;
        logic [2:0]  notify_mask;
        logic        err_enable;
        t_bus_phase  phase;
        logic [7:0]  pointer;
        logic [7:0]  regs [REG_COUNT];
        t_bus_result expected_q [$];
        int          errors;
        int          checked;

        function new();
            own_addr    = '0;
            version     = '0;
            notify_mask = '0;
            err_enable  = 1'b0;
            phase       = PHASE_IDLE;
            pointer     = '0;
            foreach (regs[i]) regs[i] = '0;
            errors      = 0;
            checked     = 0;
        endfunction

        function void write_config(logic [1:0] index, logic [7:0] data);
            case (index)
                CFG_OWN_ADDR:    own_addr = data[6:0];
                CFG_VERSION: begin
                    version = data;
                    regs[SLOT_VERSION] = data;
                end
                CFG_NOTIFY_MASK: notify_mask = data[2:0];
                CFG_ERR_ENABLE:  err_enable = data[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] scaled(int value, int divisor);
            int q;
            q = value / divisor;
            if (q < 0) q = 0;
            if (q > 255) q = 255;
            return q[7:0];
        endfunction

        function void apply_rule(logic [7:0] idx, int value);
            case (idx)
                SLOT_SWITCH, SLOT_LED1, SLOT_LED2, SLOT_FAULT:
                    regs[idx] = {7'd0, value != 0};
                SLOT_CURRENT: regs[idx] = scaled(value, DIV_CURRENT);
                SLOT_VOLTAGE: regs[idx] = scaled(value, DIV_VOLTAGE);
                SLOT_POWER:   regs[idx] = scaled(value, DIV_POWER);
                default: ;
            endcase
        endfunction

        function void note_event(logic [2:0] kind, logic [7:0] data_byte,
                                 logic [2:0] lreg, int lval);
            t_bus_result r;
            r = '0;
            case (kind)
                KIND_ADDR: begin
                    if (data_byte == {1'b0, own_addr}) begin
                        phase = PHASE_ADDRESSED;
                        r.response = RESP_ACK;
                    end
                end
                KIND_READ: begin
                    if (pointer < REG_COUNT) begin
                        r.read_valid = 1'b1;
                        r.read_data = regs[pointer];
                        pointer = (pointer == REG_COUNT - 1) ? 8'd0 : pointer + 8'd1;
                    end
                end
                KIND_WRITE: begin
                    if (phase == PHASE_ADDRESSED) begin
                        pointer = data_byte;
                        r.response = RESP_ACK;
                        phase = PHASE_DATA;
                    end else if (phase == PHASE_DATA && pointer < REG_COUNT) begin
                        apply_rule(pointer, int'(data_byte));
                        if ((pointer == SLOT_SWITCH || pointer == SLOT_LED1 ||
                             pointer == SLOT_LED2) && notify_mask[pointer - 8'd1]) begin
                            r.notify_valid = 1'b1;
                            r.notify_reg = pointer[2:0];
                            r.notify_value = regs[pointer][0];
                        end
                        if (pointer == REG_COUNT - 1) begin
                            pointer = 8'd0;
                            r.response = RESP_NACK;
                        end else begin
                            pointer = pointer + 8'd1;
                            r.response = RESP_ACK;
                        end
                    end
                end
                KIND_STOP: phase = PHASE_IDLE;
                KIND_COLL, KIND_BUS_ERR: begin
                    if (err_enable) r.error_code = (kind == KIND_COLL) ? ERR_COLL : ERR_BUS;
                    phase = PHASE_IDLE;
                end
                KIND_LOCAL: begin
                    if (lreg < REG_COUNT) apply_rule({5'd0, lreg}, lval);
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_bus_result got);
            t_bus_result exp_r;
            if (expected_q.size() == 0) begin
                $error("result transaction with no event outstanding");
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            check_field("response", 8'(exp_r.response), 8'(got.response));
            check_field("read_valid", 8'(exp_r.read_valid), 8'(got.read_valid));
            check_field("read_data", exp_r.read_data, got.read_data);
            check_field("notify_valid", 8'(exp_r.notify_valid), 8'(got.notify_valid));
            check_field("notify_reg", 8'(exp_r.notify_reg), 8'(got.notify_reg));
            check_field("notify_value", 8'(exp_r.notify_value), 8'(got.notify_value));
            check_field("error_code", 8'(exp_r.error_code), 8'(got.error_code));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_kind = '0;
    logic [7:0]         i_bus_byte = '0;
    logic [2:0]         i_local_reg = '0;
    logic signed [31:0] i_local_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_response;
    logic               o_read_valid;
    logic [7:0]         o_read_data;
    logic               o_notify_valid;
    logic [2:0]         o_notify_reg;
    logic               o_notify_value;
    logic [1:0]         o_error_code;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [7:0]         i_cfg_data = '0;

    reg_file_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int events_sent = 0;
    int cfg_writes = 0;

    i2c_target_register_file_top #(
        .NUM_REGS(REG_COUNT)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_bus_byte     (i_bus_byte),
        .i_local_reg    (i_local_reg),
        .i_local_value  (i_local_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_response     (o_response),
        .o_read_valid   (o_read_valid),
        .o_read_data    (o_read_data),
        .o_notify_valid (o_notify_valid),
        .o_notify_reg   (o_notify_reg),
        .o_notify_value (o_notify_value),
        .o_error_code   (o_error_code),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_config(i_cfg_index, i_cfg_data);
            if (o_out_valid && i_out_ready) begin
                sb.check_result({o_response, o_read_valid, o_read_data, o_notify_valid,
                                 o_notify_reg, o_notify_value, o_error_code});
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_event(i_kind, i_bus_byte, i_local_reg, int'(i_local_value));
            end
        end
    end

    task automatic send_event(logic [2:0] kind, logic [7:0] data_byte,
                              logic [2:0] lreg, logic [31:0] lval);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_bus_byte    <= data_byte;
        i_local_reg   <= lreg;
        i_local_value <= lval;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        events_sent++;
    endtask

    task automatic bus_event(logic [2:0] kind, logic [7:0] data_byte);
        send_event(kind, data_byte, 3'($urandom), $urandom);
    endtask

    task automatic local_update(logic [2:0] lreg, logic [31:0] lval);
        send_event(KIND_LOCAL, 8'($urandom), lreg, lval);
    endtask

    // hold off new events until every outstanding result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] index, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_writes++;
    endtask

    task automatic set_config(logic [7:0] own, logic [7:0] ver, logic [7:0] mask,
                              logic [7:0] err_en);
        cfg_write(CFG_OWN_ADDR, own);
        cfg_write(CFG_VERSION, ver);
        cfg_write(CFG_NOTIFY_MASK, mask);
        cfg_write(CFG_ERR_ENABLE, err_en);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(4))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_pointer();
        if ($urandom_range(9) != 0) return 8'($urandom_range(REG_COUNT - 1));
        return 8'($urandom);
    endfunction

    function automatic logic [31:0] pick_local_value();
        logic signed [31:0] lim;
        case ($urandom_range(2))
            0: lim = LIM_CURRENT;
            1: lim = LIM_VOLTAGE;
            default: lim = LIM_POWER;
        endcase
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($urandom_range(40000));
            2: return 32'(-int'($urandom_range(40000)));
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            default: return lim + 32'($urandom_range(6)) - 32'd3;
        endcase
    endfunction

    task automatic end_transfer();
        int roll;
        roll = $urandom_range(19);
        if (roll < 17) bus_event(KIND_STOP, 8'($urandom));
        else if (roll == 17) bus_event(KIND_COLL, 8'($urandom));
        else if (roll == 18) bus_event(KIND_BUS_ERR, 8'($urandom));
    endtask

    task automatic directed_checks();
        int i;
        set_config(8'hD0, 8'hA5, 8'h07, 8'h01);
        bus_event(KIND_READ, 8'h00);
        bus_event(KIND_WRITE, 8'h33);       // write while idle
        bus_event(KIND_ADDR, 8'h51);
        bus_event(KIND_ADDR, 8'hD0);        // msb set never matches
        bus_event(KIND_ADDR, 8'h50);
        bus_event(KIND_WRITE, 8'h01);
        bus_event(KIND_WRITE, 8'h01);
        bus_event(KIND_WRITE, 8'h00);
        bus_event(KIND_WRITE, 8'hFF);
        bus_event(KIND_WRITE, 8'h80);
        bus_event(KIND_WRITE, 8'hFF);
        bus_event(KIND_WRITE, 8'hFF);
        bus_event(KIND_WRITE, 8'hFF);       // wraps, NACK
        bus_event(KIND_WRITE, 8'h77);       // version slot ignores writes
        bus_event(KIND_STOP, 8'h00);
        bus_event(KIND_ADDR, 8'h50);
        bus_event(KIND_WRITE, 8'hFF);       // pointer out of range
        bus_event(KIND_WRITE, 8'h12);
        bus_event(KIND_READ, 8'h00);
        bus_event(KIND_COLL, 8'h00);
        bus_event(KIND_BUS_ERR, 8'h00);
        local_update(3'd5, 32'h8000_0000);
        local_update(3'd6, 32'h7FFF_FFFF);
        local_update(3'd7, 32'd32000);
        local_update(3'd7, 32'd31999);
        local_update(3'd0, 32'd9);
        bus_event(KIND_UNUSED, 8'hFF);
        bus_event(KIND_ADDR, 8'h50);
        bus_event(KIND_WRITE, 8'h00);
        for (i = 0; i < REG_COUNT; i++) bus_event(KIND_READ, 8'h00);
        bus_event(KIND_STOP, 8'h00);
    endtask

    task automatic run_random(int count);
        int target;
        int roll;
        int n;
        logic [7:0] own_byte;
        target = events_sent + count;
        while (events_sent < target) begin
            own_byte = {1'b0, sb.own_addr};
            roll = $urandom_range(19);
            if (roll < 8) begin
                bus_event(KIND_ADDR, own_byte);
                bus_event(KIND_WRITE, pick_pointer());
                n = $urandom_range(9, 1);
                repeat (n) bus_event(KIND_WRITE, pick_data());
                end_transfer();
            end else if (roll < 13) begin
                bus_event(KIND_ADDR, own_byte);
                bus_event(KIND_WRITE, pick_pointer());
                bus_event(KIND_ADDR, own_byte);
                n = $urandom_range(9, 1);
                repeat (n) bus_event(KIND_READ, 8'($urandom));
                end_transfer();
            end else if (roll < 16) begin
                n = $urandom_range(3, 1);
                repeat (n) local_update(3'($urandom), pick_local_value());
            end else begin
                bus_event(3'($urandom_range(7)),
                          $urandom_range(1) ? own_byte : 8'($urandom));
            end
            if ($urandom_range(199) == 0) drain();
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 33;
        recv_idle_pct = 46;
        directed_checks();
        drain();
        set_config(8'h00, 8'hFF, 8'h07, 8'h01);
        run_random(BLOCK_EVENTS);
        drain();
        set_config(8'hFF, 8'h00, 8'h00, 8'h00);
        run_random(BLOCK_EVENTS);
        drain();

        send_idle_pct = 46;
        recv_idle_pct = 33;
        set_config(8'($urandom), 8'($urandom), 8'h05, 8'h01);
        run_random(BLOCK_EVENTS);
        drain();
        set_config(8'($urandom), 8'($urandom), 8'h02, 8'h00);
        run_random(BLOCK_EVENTS);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(8'h2C, 8'h3C, 8'h03, 8'h01);
        run_random(BLOCK_EVENTS);
        drain();
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random(BLOCK_EVENTS);
        drain();

        $display("coverage: %0d bus/local events, %0d results checked, %0d config writes",
                 events_sent, sb.checked, cfg_writes);
        $display("  under three idle/stall mixes and seven register settings");
        if (sb.errors == 0) begin
            $display("i2c_target_register_file_top_tb: done, clean");
        end else begin
            $display("i2c_target_register_file_top_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("i2c_target_register_file_top_tb: done, errors");
        $finish;
    end

endmodule
